>>> src/iraloc_pkg.sv
// Package with shared widths and defaults for the interval room allocator.
`timescale 1ns / 1ps
`default_nettype none

package iraloc_pkg;

  localparam int MAX_ROOMS_DEFAULT = 256;
  localparam int TAG_BITS_DEFAULT  = 20;

  localparam int DAY_W      = 32;
  localparam int TAG_W      = 20;
  localparam int OUT_ROOM_W = 9;

  // Input tdata: arrival, departure and tag, padded to whole bytes.
  localparam int IN_TDATA_W  = 88;
  // Output tdata: tag, room, opened_new, rooms_used and overflow.
  localparam int OUT_TDATA_W = 40;

endpackage

`default_nettype wire

>>> src/iraloc_ram.sv
// Generic simple RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module iraloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> src/iraloc_key_cmp.sv
// Shared key comparator: unsigned less-than on packed (departure, room) keys.
`timescale 1ns / 1ps
`default_nettype none

module iraloc_key_cmp #(
  parameter int KEY_W = 41
) (
  input  logic [KEY_W-1:0] key_a,
  input  logic [KEY_W-1:0] key_b,
  output logic             a_less
);

  // Departure sits in the high bits, so one compare orders the pair
  // lexicographically.
  assign a_less = (key_a < key_b);

endmodule

`default_nettype wire

>>> src/interval_room_allocator_core.sv
// Top level of the interval room allocator: heap sequencer and stream ports.
//
// Requests enter on the s_axis channel, one transaction each, in arrival order.
// s_axis_tuser carries the restart flag, which empties the heap and the room
// count before that request is handled. Every request gives exactly one
// result transaction on m_axis with its tag, room, new-room flag, running room
// count and overflow flag.
// Occupied rooms live in a binary min-heap held in a two-read, one-write RAM,
// keyed by (departure, room). A single comparator is shared by every step.
// An item is accepted and then tested against the heap top. A reused room then
// takes a RAM read, a child compare and a parent compare for each child pair
// it is compared against, plus a final read at a leaf; a new room takes a
// parent read and compare for each parent it is compared against, plus a
// final step at the root; a request past capacity goes straight on. A last
// step loads the result into the output register.
// Results wait in an output register; a stalled receiver holds the finished
// result there while the next request is already accepted, and the following
// one finishes only once that register is free. s_axis_tready is high only
// while the sequencer is idle and reset is low. Reset empties the heap and
// zeroes the room count at once; only entries below the count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module interval_room_allocator_core #(
  parameter int MAX_ROOMS = iraloc_pkg::MAX_ROOMS_DEFAULT,
  parameter int TAG_BITS  = iraloc_pkg::TAG_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: arrival_day[31:0], departure_day[63:32],
  // request_tag[83:64], zero padding[87:84].
  input  logic [iraloc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0: restart[0].
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: request_tag_out[19:0], room[28:20], opened_new[29],
  // rooms_used[38:30], overflow[39].
  output logic [iraloc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import iraloc_pkg::*;

  localparam int IDX_W = $clog2(MAX_ROOMS);
  localparam int CNT_W = $clog2(MAX_ROOMS + 1);
  localparam int KEY_W = DAY_W + CNT_W;
  localparam int CHD_W = IDX_W + 2;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROOMS);
  localparam logic [TAG_W-1:0] TAG_MASK = (TAG_BITS >= TAG_W) ? {TAG_W{1'b1}} :
                                          TAG_W'((64'd1 << TAG_BITS) - 64'd1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_CHECK   = 3'd1;
  localparam logic [2:0] ST_SD_READ = 3'd2;
  localparam logic [2:0] ST_SD_PICK = 3'd3;
  localparam logic [2:0] ST_SD_MOVE = 3'd4;
  localparam logic [2:0] ST_SU_STEP = 3'd5;
  localparam logic [2:0] ST_SU_CMP  = 3'd6;
  localparam logic [2:0] ST_FINISH  = 3'd7;

  logic [2:0]             state;
  logic [CNT_W-1:0]       count;
  logic                   out_valid;

  logic [IDX_W-1:0]       pos;
  logic [DAY_W-1:0]       arrival;
  logic [DAY_W-1:0]       departure;
  logic [TAG_W-1:0]       tag;
  logic [KEY_W-1:0]       item_key;
  logic [KEY_W-1:0]       best_key;
  logic [IDX_W-1:0]       best_idx;
  logic                   right_ok;
  logic [CNT_W-1:0]       res_room;
  logic                   res_fresh;
  logic                   res_over;
  logic [OUT_TDATA_W-1:0] out_data;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [KEY_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]       ram_raddr_a;
  logic [IDX_W-1:0]       ram_raddr_b;
  logic [KEY_W-1:0]       ram_rdata_a;
  logic [KEY_W-1:0]       ram_rdata_b;

  logic [KEY_W-1:0]       cmp_a;
  logic [KEY_W-1:0]       cmp_b;
  logic                   key_lt;

  logic [CHD_W-1:0]       left_idx;
  logic [CHD_W-1:0]       right_idx;
  logic [CHD_W-1:0]       count_ext;
  logic                   left_v;
  logic                   right_v;
  logic [IDX_W-1:0]       parent_idx;
  logic [CNT_W-1:0]       new_room;
  logic                   in_take;
  logic                   out_free;
  logic                   res_load;
  logic [CNT_W+8:0]       room_wide;
  logic [CNT_W+8:0]       used_wide;

  iraloc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ROOMS)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (ram_rdata_a),
    .rdata_b (ram_rdata_b)
  );

  iraloc_key_cmp #(
    .KEY_W (KEY_W)
  ) u_key_cmp (
    .key_a  (cmp_a),
    .key_b  (cmp_b),
    .a_less (key_lt)
  );

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign res_load      = (state == ST_FINISH) && out_free;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign left_idx   = CHD_W'({pos, 1'b1});
  assign right_idx  = left_idx + CHD_W'(1);
  assign count_ext  = CHD_W'(count);
  assign left_v     = (left_idx < count_ext);
  assign right_v    = (right_idx < count_ext);
  assign parent_idx = IDX_W'((pos - IDX_W'(1)) >> 1);
  assign new_room   = count + CNT_W'(1);
  assign room_wide  = {9'd0, res_room};
  assign used_wide  = {9'd0, count};

  // Operand selection for the shared comparator.
  always_comb begin
    unique case (state)
      ST_CHECK: begin
        // Heap top departs strictly before arrival iff its key is below
        // (arrival, 0).
        cmp_a = ram_rdata_a;
        cmp_b = {arrival, {CNT_W{1'b0}}};
      end
      ST_SD_PICK: begin
        cmp_a = ram_rdata_b;
        cmp_b = ram_rdata_a;
      end
      ST_SD_MOVE: begin
        cmp_a = best_key;
        cmp_b = item_key;
      end
      ST_SU_CMP: begin
        cmp_a = item_key;
        cmp_b = ram_rdata_a;
      end
      default: begin
        cmp_a = ram_rdata_a;
        cmp_b = item_key;
      end
    endcase
  end

  // Heap RAM access. The moving item is held aside and the hole it leaves is
  // filled as it travels, so each level takes one write.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = item_key;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    unique case (state)
      ST_SD_READ: begin
        ram_raddr_a = left_idx[IDX_W-1:0];
        ram_raddr_b = right_idx[IDX_W-1:0];
        ram_we      = !left_v;
      end
      ST_SD_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = key_lt ? best_key : item_key;
      end
      ST_SU_STEP: begin
        ram_raddr_a = parent_idx;
        ram_we      = (pos == '0);
      end
      ST_SU_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = key_lt ? ram_rdata_a : item_key;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer, room count and output handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (s_axis_tuser) begin
              count <= '0;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (count != '0 && key_lt) begin
            state <= ST_SD_READ;
          end else if (count < MAX_CNT) begin
            count <= new_room;
            state <= ST_SU_STEP;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SD_READ: begin
          state <= left_v ? ST_SD_PICK : ST_FINISH;
        end
        ST_SD_PICK: begin
          state <= ST_SD_MOVE;
        end
        ST_SD_MOVE: begin
          state <= key_lt ? ST_SD_READ : ST_FINISH;
        end
        ST_SU_STEP: begin
          state <= (pos == '0) ? ST_FINISH : ST_SU_CMP;
        end
        ST_SU_CMP: begin
          state <= key_lt ? ST_SU_STEP : ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item payload and result registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          arrival   <= s_axis_tdata[31:0];
          departure <= s_axis_tdata[63:32];
          tag       <= s_axis_tdata[83:64] & TAG_MASK;
        end
      end
      ST_CHECK: begin
        res_fresh <= 1'b0;
        res_over  <= 1'b0;
        if (count != '0 && key_lt) begin
          res_room <= ram_rdata_a[CNT_W-1:0];
          item_key <= {departure, ram_rdata_a[CNT_W-1:0]};
          pos      <= '0;
        end else if (count < MAX_CNT) begin
          res_room  <= new_room;
          res_fresh <= 1'b1;
          item_key  <= {departure, new_room};
          pos       <= count[IDX_W-1:0];
        end else begin
          res_room <= '0;
          res_over <= 1'b1;
        end
      end
      ST_SD_READ: begin
        right_ok <= right_v;
      end
      ST_SD_PICK: begin
        if (right_ok && key_lt) begin
          best_key <= ram_rdata_b;
          best_idx <= right_idx[IDX_W-1:0];
        end else begin
          best_key <= ram_rdata_a;
          best_idx <= left_idx[IDX_W-1:0];
        end
      end
      ST_SD_MOVE: begin
        if (key_lt) begin
          pos <= best_idx;
        end
      end
      ST_SU_CMP: begin
        if (key_lt) begin
          pos <= parent_idx;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data <= {res_over, used_wide[8:0], res_fresh, room_wide[8:0], tag};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> verif/interval_room_allocator_core_tb.sv
// Self-checking testbench for the interval room allocator core.
`timescale 1ns / 1ps

module interval_room_allocator_core_tb;
  import iraloc_pkg::*;

  localparam int ROOM_CAPACITY = MAX_ROOMS_DEFAULT;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [TAG_W-1:0]      tag;
    logic [OUT_ROOM_W-1:0] room;
    logic                  opened_new;
    logic [OUT_ROOM_W-1:0] rooms_used;
    logic                  overflow;
  } room_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow copy of the occupied-room heap, keyed by (departure, room).
  logic [DAY_W-1:0]      shadow_departure[ROOM_CAPACITY];
  logic [OUT_ROOM_W-1:0] shadow_room[ROOM_CAPACITY];
  int unsigned shadow_heap_size = 0;
  int unsigned shadow_rooms_opened = 0;

  room_result_t expected_rooms[$];
  int unsigned mismatch_count = 0;
  int unsigned requests_sent = 0;
  bit no_idle = 1'b0;

  interval_room_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic bit slot_precedes(int unsigned i, int unsigned j);
    if (shadow_departure[i] != shadow_departure[j])
      return shadow_departure[i] < shadow_departure[j];
    return shadow_room[i] < shadow_room[j];
  endfunction

  function automatic void swap_slots(int unsigned i, int unsigned j);
    logic [DAY_W-1:0] dep;
    logic [OUT_ROOM_W-1:0] rm;
    dep = shadow_departure[i];
    rm = shadow_room[i];
    shadow_departure[i] = shadow_departure[j];
    shadow_room[i] = shadow_room[j];
    shadow_departure[j] = dep;
    shadow_room[j] = rm;
  endfunction

  function automatic void sink_top();
    int unsigned pos;
    int unsigned best;
    int unsigned left;
    pos = 0;
    forever begin
      left = 2 * pos + 1;
      best = pos;
      if (left < shadow_heap_size && slot_precedes(left, best))
        best = left;
      if (left + 1 < shadow_heap_size && slot_precedes(left + 1, best))
        best = left + 1;
      if (best == pos)
        return;
      swap_slots(pos, best);
      pos = best;
    end
  endfunction

  function automatic void raise_slot(int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!slot_precedes(pos, parent))
        return;
      swap_slots(pos, parent);
      pos = parent;
    end
  endfunction

  // Greedy interval partitioning: reuse the earliest-freed room if it is free
  // strictly before the arrival, otherwise open the next room number or flag overflow.
  function automatic room_result_t assign_room(logic [DAY_W-1:0] arrival,
                                               logic [DAY_W-1:0] departure,
                                               logic [TAG_W-1:0] tag,
                                               logic restart);
    room_result_t res;
    res.tag = tag;
    res.room = '0;
    res.opened_new = 1'b0;
    res.overflow = 1'b0;
    if (restart) begin
      shadow_heap_size = 0;
      shadow_rooms_opened = 0;
    end
    if (shadow_heap_size > 0 && shadow_departure[0] < arrival) begin
      res.room = shadow_room[0];
      shadow_departure[0] = departure;
      sink_top();
    end else if (shadow_rooms_opened < ROOM_CAPACITY && shadow_heap_size < ROOM_CAPACITY) begin
      shadow_rooms_opened++;
      shadow_departure[shadow_heap_size] = departure;
      shadow_room[shadow_heap_size] = OUT_ROOM_W'(shadow_rooms_opened);
      shadow_heap_size++;
      raise_slot(shadow_heap_size - 1);
      res.room = OUT_ROOM_W'(shadow_rooms_opened);
      res.opened_new = 1'b1;
    end else begin
      res.overflow = 1'b1;
    end
    res.rooms_used = OUT_ROOM_W'(shadow_rooms_opened);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want,
                                 logic [TAG_W-1:0] tag);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t ns: mismatch on %s for tag 0x%05h: got 0x%0h, expected 0x%0h",
               $time, what, tag, got, want);
  endtask

  // Sends one request and records its expected result once the transaction
  // has been accepted. Valid stays high between back-to-back requests.
  task automatic send_request(logic [DAY_W-1:0] arrival, logic [DAY_W-1:0] departure,
                              logic [TAG_W-1:0] tag, logic restart);
    int unsigned gap;
    room_result_t want;
    if (!no_idle && $urandom_range(0, 99) < 28) begin
      gap = $urandom_range(1, 30);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, tag, departure, arrival};
    s_axis_tuser <= restart;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    want = assign_room(arrival, departure, tag, restart);
    expected_rooms = {expected_rooms, want};
    requests_sent++;
  endtask

  task automatic check_result(logic [OUT_TDATA_W-1:0] data);
    room_result_t want;
    logic [TAG_W-1:0] tag;
    tag = data[19:0];
    if (expected_rooms.size() == 0) begin
      report_mismatch("unexpected result", 64'(data), 64'(0), tag);
      return;
    end
    want = expected_rooms.pop_front();
    if (tag != want.tag)
      report_mismatch("request_tag_out", 64'(tag), 64'(want.tag), want.tag);
    if (data[28:20] != want.room)
      report_mismatch("room", 64'(data[28:20]), 64'(want.room), want.tag);
    if (data[29] != want.opened_new)
      report_mismatch("opened_new", 64'(data[29]), 64'(want.opened_new), want.tag);
    if (data[38:30] != want.rooms_used)
      report_mismatch("rooms_used", 64'(data[38:30]), 64'(want.rooms_used), want.tag);
    if (data[39] != want.overflow)
      report_mismatch("overflow", 64'(data[39]), 64'(want.overflow), want.tag);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      check_result(m_axis_tdata);
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 28);
  end

  // Ties, reuse of the earliest-freed room, extreme day values, departures
  // before arrivals, out-of-order arrivals and a restart in mid batch.
  task automatic test_basic_cases();
    send_request(32'd0, 32'd0, 20'h00000, 1'b1);
    send_request(32'd0, 32'd0, 20'h00001, 1'b0);
    send_request(32'd1, 32'hFFFF_FFFF, 20'hFFFFF, 1'b0);
    send_request(32'd1, 32'd5, 20'hAAAAA, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'h55555, 1'b0);
    send_request(32'hFFFF_FFFF, 32'd0, 20'h00002, 1'b0);
    send_request(32'd3, 32'd2, 20'h00003, 1'b0);
    send_request(32'd2, 32'd2, 20'h00004, 1'b0);
    send_request(32'd10, 32'd20, 20'h00005, 1'b1);
    send_request(32'd10, 32'd15, 20'h00006, 1'b0);
    send_request(32'd16, 32'd30, 20'h00007, 1'b0);
    send_request(32'd21, 32'd22, 20'h00008, 1'b0);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 20'h0F0F0, 1'b0);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 20'hF0F0F, 1'b0);
    send_request(32'h8000_0000, 32'h8000_0001, 20'h80000, 1'b1);
    send_request(32'h8000_0002, 32'h8000_0002, 20'h40000, 1'b0);
    send_request(32'h8000_0002, 32'h8000_0003, 20'h20000, 1'b0);
    send_request(32'h8000_0004, 32'hFFFF_FFFE, 20'h10000, 1'b0);
  endtask

  // Fills every room, runs past capacity, then reuses rooms across a full heap.
  task automatic test_room_capacity();
    logic [DAY_W-1:0] arrival;
    arrival = 32'd1_000_001;
    for (int i = 0; i < ROOM_CAPACITY + 3; i++)
      send_request(32'd0, $urandom_range(0, 1_000_000), TAG_W'($urandom()), i == 0);
    for (int i = 0; i < 40; i++) begin
      arrival = arrival + $urandom_range(0, 3);
      send_request(arrival, arrival + $urandom_range(0, 500), TAG_W'($urandom()), 1'b0);
    end
    send_request(32'd0, 32'd7, TAG_W'($urandom()), 1'b0);
    send_request(32'd0, 32'd7, TAG_W'($urandom()), 1'b1);
  endtask

  // Mostly well-formed batches in arrival order with random content, some of
  // them dense enough to run out of rooms, mixed with stray requests.
  task automatic test_random_batches(int unsigned target);
    int unsigned batch_len;
    int unsigned max_step;
    int unsigned max_stay;
    logic [DAY_W-1:0] arrival;
    logic [DAY_W-1:0] departure;
    logic [DAY_W-1:0] prev_departure;
    logic restart;
    while (requests_sent < target) begin
      no_idle = (requests_sent > target / 2) && (requests_sent < target / 2 + 300);
      if ($urandom_range(0, 9) == 0) begin
        batch_len = $urandom_range(100, 300);
        max_step = 1;
        max_stay = 3000;
      end else begin
        batch_len = $urandom_range(1, 40);
        max_step = $urandom_range(1, 6);
        max_stay = $urandom_range(1, 40);
      end
      arrival = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1000);
      prev_departure = '0;
      for (int i = 0; i < batch_len; i++) begin
        restart = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 99) == 0);
        if ($urandom_range(0, 19) == 0) begin
          send_request($urandom(), $urandom(), TAG_W'($urandom()), restart);
        end else begin
          int unsigned step;
          step = $urandom_range(0, max_step);
          arrival = arrival + step;
          departure = arrival + $urandom_range(0, max_stay);
          if (step == 0 && departure < prev_departure)
            departure = prev_departure;
          prev_departure = departure;
          send_request(arrival, departure, TAG_W'($urandom()), restart);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("interval_room_allocator_core_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_cases();
    test_room_capacity();
    test_random_batches(1700);
    s_axis_tvalid <= 1'b0;
    while (expected_rooms.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("interval_room_allocator_core_tb OK");
    end else begin
      $display("interval_room_allocator_core_tb NOT OK");
    end
    $finish;
  end

endmodule
